/* rtl/tars_pkg.sv */
// tars_pkg: shared types and constants for the tensor axis reduction block
// no dependencies

package tars_pkg;

   localparam int NUM_DIMS   = 6;
   localparam int X_BITS     = 32;
   localparam int YIDX_BITS  = 12;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 48;

   localparam logic [CSR_IDX_BITS-1:0] CSR_OP_SELECT   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REDUCE_MASK = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIM_SIZE_0  = 3'd2;

   localparam logic OP_SUM = 1'b0;
   localparam logic OP_MAX = 1'b1;

   typedef enum logic [1:0] {
      ST_READY,
      ST_CALC,
      ST_BASE
   } tars_state_type;

   typedef struct packed {
      logic first;
      logic last;
      logic tensor_end;
   } tars_flags_type;

endpackage

/* rtl/tars_front.sv */
// tars_front: configuration registers, coordinate counters, stride setup
// and accumulator address tracking; depends on tars_pkg

module tars_front import tars_pkg::*; #(
   parameter int MAX_DIMS  = 6,
   parameter int ACC_DEPTH = 4096,
   parameter int DIM_BITS  = 16,
   localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     q_full,
   output logic                     q_push,
   output logic [AW-1:0]            q_addr,
   output logic [YIDX_BITS-1:0]     q_yidx,
   output tars_flags_type           q_flags,
   output logic                     op_sel
);

   localparam logic [AW:0]   DEPTH_V = (AW+1)'(ACC_DEPTH);
   localparam logic [AW-1:0] ONE_V   = (ACC_DEPTH > 1) ? AW'(1) : AW'(0);
   localparam int BCW = (DIM_BITS > 1) ? $clog2(DIM_BITS) : 1;

   function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_V) s = s - DEPTH_V;
      return s[AW-1:0];
   endfunction

   logic                     op_ff, op_in;
   logic [NUM_DIMS-1:0]      mask_ff, mask_in;
   logic [CSR_DATA_BITS-1:0] size_ff  [NUM_DIMS];
   logic [CSR_DATA_BITS-1:0] size_in  [NUM_DIMS];
   logic [DIM_BITS-1:0]      coord_ff [NUM_DIMS];
   logic [DIM_BITS-1:0]      coord_in [NUM_DIMS];
   logic [AW-1:0]            base_ff  [NUM_DIMS];
   logic [AW-1:0]            base_in  [NUM_DIMS];
   logic [AW-1:0]            prod_ff  [NUM_DIMS];
   logic [AW-1:0]            prod_in  [NUM_DIMS];
   logic [YIDX_BITS-1:0]     oidx_ff, oidx_in;
   tars_state_type           state_ff, state_in;
   logic [2:0]               dp_ff, dp_in;
   logic [BCW-1:0]           bc_ff, bc_in;
   logic [AW-1:0]            r_ff, r_in;

   logic [DIM_BITS-1:0] eff_m1 [NUM_DIMS];
   logic [DIM_BITS-1:0] mult   [NUM_DIMS];
   logic [AW-1:0]       stride [NUM_DIMS];
   logic [NUM_DIMS-1:0] at_end;
   logic [2:0]          k;
   logic [2:0]          dpn;
   logic [AW-1:0]       new_addr, r_dbl, r_next, rb_next, b_prev;
   logic                tensor_end, first, last, csr_wr;

   assign csr_ready  = 1'b1;
   assign csr_wr     = csr_valid;
   assign req_tready = (state_ff == ST_READY) && !q_full;
   assign q_push     = req_tvalid && req_tready;
   assign op_sel     = op_ff;

   always_comb begin
      tensor_end = 1'b1;
      first = 1'b1;
      last = 1'b1;
      k = 3'd0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (d < NUM_DIMS - MAX_DIMS || size_ff[d][DIM_BITS-1:0] == '0) begin
            eff_m1[d] = '0;
            mult[d] = DIM_BITS'(1);
         end else begin
            eff_m1[d] = size_ff[d][DIM_BITS-1:0] - DIM_BITS'(1);
            mult[d] = size_ff[d][DIM_BITS-1:0];
         end
         if (mask_ff[d]) mult[d] = DIM_BITS'(1);
         stride[d] = mask_ff[d] ? '0 : prod_ff[d];
         at_end[d] = coord_ff[d] >= eff_m1[d];
         if (!at_end[d]) begin
            tensor_end = 1'b0;
            k = 3'(d);
         end
         if (mask_ff[d]) begin
            if (coord_ff[d] != '0) first = 1'b0;
            if (!at_end[d]) last = 1'b0;
         end
      end
      new_addr = mod_add(base_ff[k], stride[k]);
   end

   assign q_addr  = base_ff[NUM_DIMS-1];
   assign q_yidx  = oidx_ff;
   assign q_flags = '{first: first, last: last, tensor_end: tensor_end};

   assign dpn     = dp_ff + 3'd1;
   assign r_dbl   = mod_add(r_ff, r_ff);
   assign r_next  = mult[dpn][bc_ff] ? mod_add(r_dbl, prod_ff[dpn]) : r_dbl;
   assign rb_next = coord_ff[dp_ff][bc_ff] ? mod_add(r_dbl, stride[dp_ff]) : r_dbl;
   assign b_prev  = (dp_ff == '0) ? '0 : base_ff[dp_ff - 3'd1];

   always_comb begin
      op_in    = op_ff;
      mask_in  = mask_ff;
      size_in  = size_ff;
      coord_in = coord_ff;
      base_in  = base_ff;
      prod_in  = prod_ff;
      oidx_in  = oidx_ff;
      state_in = state_ff;
      dp_in    = dp_ff;
      bc_in    = bc_ff;
      r_in     = r_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_OP_SELECT:   op_in = csr_wdata[0];
            CSR_REDUCE_MASK: mask_in = csr_wdata[NUM_DIMS-1:0];
            default:         size_in[csr_index - CSR_DIM_SIZE_0] = csr_wdata;
         endcase
      end
      unique case (state_ff)
         ST_READY: begin
            if (q_push) begin
               for (int d = 0; d < NUM_DIMS; d++) begin
                  if (tensor_end) begin
                     coord_in[d] = '0;
                     base_in[d] = '0;
                  end else if (d > int'(k)) begin
                     coord_in[d] = '0;
                     base_in[d] = new_addr;
                  end else if (d == int'(k)) begin
                     coord_in[d] = coord_ff[d] + DIM_BITS'(1);
                     base_in[d] = new_addr;
                  end
               end
               if (last) oidx_in = tensor_end ? '0 : oidx_ff + YIDX_BITS'(1);
            end
         end
         ST_CALC: begin
            if (bc_ff == '0) begin
               prod_in[dp_ff] = r_next;
               r_in = '0;
               bc_in = BCW'(DIM_BITS - 1);
               if (dp_ff == '0) begin
                  state_in = ST_BASE;
                  dp_in = '0;
               end else begin
                  dp_in = dp_ff - 3'd1;
               end
            end else begin
               r_in = r_next;
               bc_in = bc_ff - BCW'(1);
            end
         end
         ST_BASE: begin
            // element address from the current coordinates and new strides
            if (bc_ff == '0) begin
               base_in[dp_ff] = mod_add(b_prev, rb_next);
               r_in = '0;
               bc_in = BCW'(DIM_BITS - 1);
               dp_in = dpn;
               if (dp_ff == 3'(NUM_DIMS - 1)) state_in = ST_READY;
            end else begin
               r_in = rb_next;
               bc_in = bc_ff - BCW'(1);
            end
         end
         default: state_in = ST_READY;
      endcase
      if (csr_wr) begin
         state_in = ST_CALC;
         dp_in = 3'(NUM_DIMS - 2);
         bc_in = BCW'(DIM_BITS - 1);
         r_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_SUM;
         mask_ff  <= '0;
         oidx_ff  <= '0;
         state_ff <= ST_READY;
         dp_ff    <= '0;
         bc_ff    <= '0;
         r_ff     <= '0;
         for (int d = 0; d < NUM_DIMS; d++) begin
            size_ff[d]  <= CSR_DATA_BITS'(1);
            coord_ff[d] <= '0;
            base_ff[d]  <= '0;
            prod_ff[d]  <= ONE_V;
         end
      end else begin
         op_ff    <= op_in;
         mask_ff  <= mask_in;
         size_ff  <= size_in;
         coord_ff <= coord_in;
         base_ff  <= base_in;
         prod_ff  <= prod_in;
         oidx_ff  <= oidx_in;
         state_ff <= state_in;
         dp_ff    <= dp_in;
         bc_ff    <= bc_in;
         r_ff     <= r_in;
      end
   end

endmodule

/* rtl/tars_queue.sv */
// tars_queue: two-entry queue between front and back
// depends on tars_pkg

module tars_queue import tars_pkg::*; #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] din,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output logic [W-1:0] dout
);

   logic [W-1:0] slot_ff [2];
   logic         wr_ff, rd_ff;
   logic [1:0]   cnt_ff;

   assign full  = cnt_ff == 2'd2;
   assign valid = cnt_ff != 2'd0;
   assign dout  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= din;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

/* rtl/tars_back.sv */
// tars_back: accumulator memory read-modify-write with forwarding and
// output register; depends on tars_pkg

module tars_back import tars_pkg::*; #(
   parameter int ACC_DEPTH = 4096,
   localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_sel,
   input  logic                     q_valid,
   output logic                     q_pop,
   input  logic [X_BITS-1:0]        q_x,
   input  logic [AW-1:0]            q_addr,
   input  logic [YIDX_BITS-1:0]     q_yidx,
   input  tars_flags_type           q_flags,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast
);

   logic [X_BITS-1:0]    acc_mem [ACC_DEPTH];
   logic [X_BITS-1:0]    rd_ff;
   logic                 s2_valid_ff;
   logic [X_BITS-1:0]    s2_x_ff;
   logic [AW-1:0]        s2_addr_ff;
   logic [YIDX_BITS-1:0] s2_yidx_ff;
   tars_flags_type       s2_flags_ff;
   logic                 lw_valid_ff;
   logic [AW-1:0]        lw_addr_ff;
   logic [X_BITS-1:0]    lw_data_ff;
   logic                 out_valid_ff;
   logic [X_BITS-1:0]    out_val_ff;
   logic [YIDX_BITS-1:0] out_idx_ff;
   logic                 out_last_ff;
   logic                 fire;
   logic [X_BITS-1:0]    old_val, acc_in;

   assign fire  = s2_valid_ff && (!s2_flags_ff.last || !out_valid_ff || rsp_tready);
   assign q_pop = q_valid && (!s2_valid_ff || fire);

   always_comb begin
      old_val = (lw_valid_ff && lw_addr_ff == s2_addr_ff) ? lw_data_ff : rd_ff;
      if (s2_flags_ff.first) acc_in = s2_x_ff;
      else if (op_sel == OP_SUM) acc_in = old_val + s2_x_ff;
      else acc_in = ($signed(old_val) < $signed(s2_x_ff)) ? s2_x_ff : old_val;
   end

   always_ff @(posedge clock) begin
      if (q_pop) rd_ff <= acc_mem[q_addr];
      if (fire) acc_mem[s2_addr_ff] <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s2_x_ff     <= q_x;
         s2_addr_ff  <= q_addr;
         s2_yidx_ff  <= q_yidx;
         s2_flags_ff <= q_flags;
      end
      if (fire) begin
         lw_addr_ff <= s2_addr_ff;
         lw_data_ff <= acc_in;
      end
      if (fire && s2_flags_ff.last) begin
         out_val_ff  <= acc_in;
         out_idx_ff  <= s2_yidx_ff;
         out_last_ff <= s2_flags_ff.tensor_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) s2_valid_ff <= 1'b1;
         else if (fire) s2_valid_ff <= 1'b0;
         if (fire) lw_valid_ff <= 1'b1;
         if (fire && s2_flags_ff.last) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - X_BITS - YIDX_BITS)'(0), out_idx_ff, out_val_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

/* rtl/tensor_axis_reduce_sum_max_top.sv */
// result path: req -> queue -> read stage -> output register -> rsp_tvalid
// throughput: one element per cycle, limited by the accumulator read-modify-write
// and stalls under rsp back-pressure; a csr write drops req_tready while
// strides and the element address are rebuilt
// reset is synchronous, active high; it clears counters and configuration
// the accumulator memory is not cleared; entries are written before use
// top level: tars_front, tars_queue, tars_back; depends on tars_pkg

module tensor_axis_reduce_sum_max_top import tars_pkg::*; #(
   parameter int MAX_DIMS  = 6,
   parameter int ACC_DEPTH = 4096,
   parameter int DIM_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [X_BITS-1:0]        req_tdata,   // x_value
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,   // y_value, y_index, zero fill
   output logic                     rsp_tlast
);

   localparam int AW = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
   localparam int FW = $bits(tars_flags_type);
   localparam int QW = X_BITS + YIDX_BITS + AW + FW;

   logic                 q_full, q_push, q_valid, q_pop, op_sel;
   logic [AW-1:0]        f_addr;
   logic [YIDX_BITS-1:0] f_yidx;
   tars_flags_type       f_flags, b_flags;
   logic [QW-1:0]        q_din, q_dout;

   tars_front #(
      .MAX_DIMS (MAX_DIMS),
      .ACC_DEPTH(ACC_DEPTH),
      .DIM_BITS (DIM_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_addr    (f_addr),
      .q_yidx    (f_yidx),
      .q_flags   (f_flags),
      .op_sel    (op_sel)
   );

   assign q_din = {f_flags, f_yidx, f_addr, req_tdata};

   tars_queue #(.W(QW)) u_queue (
      .clock(clock),
      .reset(reset),
      .push (q_push),
      .din  (q_din),
      .full (q_full),
      .pop  (q_pop),
      .valid(q_valid),
      .dout (q_dout)
   );

   assign b_flags = tars_flags_type'(q_dout[QW-1 -: FW]);

   tars_back #(.ACC_DEPTH(ACC_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_sel    (op_sel),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_x       (q_dout[X_BITS-1:0]),
      .q_addr    (q_dout[X_BITS +: AW]),
      .q_yidx    (q_dout[X_BITS+AW +: YIDX_BITS]),
      .q_flags   (b_flags),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

/* rtl/tars_checker.sv */
// tars_checker: port-level assertions for the reduction top level
// depends on tars_pkg; bound to tensor_axis_reduce_sum_max_top

module tars_checker import tars_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     csr_valid,
   input logic                     csr_ready,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast
);

   logic [YIDX_BITS-1:0] exp_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         exp_idx_ff <= rsp_tlast ? '0 : exp_idx_ff + YIDX_BITS'(1);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction dropped or changed while stalled");

   a_rst_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_idx_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> rsp_tdata[X_BITS +: YIDX_BITS] == exp_idx_ff)
      else $error("output index out of sequence");

   a_cfg_stall: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("req accepted while strides are rebuilt");

endmodule

bind tensor_axis_reduce_sum_max_top tars_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);

/* bench/tensor_axis_reduce_sum_max_top_tb.sv */
// testbench for tensor_axis_reduce_sum_max_top: streams int32 tensors through the
// block under several shapes, masks and operators, predicts each reduced output
// depends on tars_pkg and the rtl of the block
`timescale 1ns / 100ps

module tensor_axis_reduce_sum_max_top_tb;
   import tars_pkg::*;

   typedef struct {
      logic [31:0] value;
      logic [11:0] index;
      logic        last;
   } reduced_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [X_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic rsp_tlast;

   tensor_axis_reduce_sum_max_top DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic        cfg_op;
   logic [5:0]  cfg_mask;
   logic [15:0] cfg_size [6];
   logic [15:0] coord [6];
   logic [11:0] out_count;
   logic [31:0] acc_mem [4096];

   reduced_type expected_q [$];
   int errors = 0;
   int elements_sent = 0;
   int outputs_seen = 0;
   int tensors_done = 0;
   longint cycles = 0;
   int stall_mode = 0;

   function automatic logic [15:0] size_of(int d);
      return (cfg_size[d] == 0) ? 16'd1 : cfg_size[d];
   endfunction

   function automatic void predict_element(logic [31:0] x);
      logic [31:0] idx;
      logic [31:0] acc;
      logic first, last, tend, fin;
      reduced_type r;
      idx = 0; first = 1; last = 1; tend = 1;
      for (int d = 0; d < 6; d++) begin
         fin = ({16'd0, coord[d]} >= {16'd0, size_of(d)} - 32'd1);
         if (!fin) tend = 0;
         if (cfg_mask[d]) begin
            if (coord[d] != 0) first = 0;
            if (!fin) last = 0;
         end else begin
            idx = idx * size_of(d) + coord[d];
         end
      end
      if (first) begin
         acc = x;
      end else begin
         acc = acc_mem[idx[11:0]];
         if (cfg_op == OP_SUM) acc = acc + x;
         else if ($signed(acc) < $signed(x)) acc = x;
      end
      acc_mem[idx[11:0]] = acc;
      if (last) begin
         r.value = acc; r.index = out_count; r.last = tend;
         expected_q.insert(expected_q.size(), r);
         out_count = tend ? 12'd0 : out_count + 12'd1;
      end
      for (int d = 5; d >= 0; d--) begin
         if ({16'd0, coord[d]} >= {16'd0, size_of(d)} - 32'd1) begin
            coord[d] = 0;
         end else begin
            coord[d] = coord[d] + 16'd1;
            break;
         end
      end
   endfunction

   // result checker with its own stall pattern
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd2000000) begin
         $display("TB_ERROR");
         $finish;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected output value %h", rsp_tdata[31:0]);
               errors++;
            end else begin
               reduced_type e;
               e = expected_q.pop_front();
               outputs_seen++;
               if (rsp_tdata[31:0] !== e.value) begin
                  $error("y_value expected %h actual %h", e.value, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[43:32] !== e.index) begin
                  $error("y_index expected %0d actual %0d", e.index, rsp_tdata[43:32]);
                  errors++;
               end
               if (rsp_tdata[47:44] !== 4'd0) begin
                  $error("rsp fill expected 0 actual %h", rsp_tdata[47:44]);
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("y_last expected %b actual %b", e.last, rsp_tlast);
                  errors++;
               end
               if (e.last) tensors_done++;
            end
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= cycles[3];
         endcase
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      end
   end

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_OP_SELECT) cfg_op = data[0];
      else if (idx == CSR_REDUCE_MASK) cfg_mask = data[5:0];
      else cfg_size[idx - CSR_DIM_SIZE_0] = data;
   endtask

   // waits for outstanding outputs, then the pipeline latency
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic configure(logic op, logic [5:0] mask, int s0, int s1, int s2,
                            int s3, int s4, int s5);
      drain();
      write_csr(CSR_OP_SELECT, {15'd0, op});
      write_csr(CSR_REDUCE_MASK, {10'd0, mask});
      write_csr(CSR_DIM_SIZE_0, s0[15:0]);
      write_csr(CSR_DIM_SIZE_0 + 3'd1, s1[15:0]);
      write_csr(CSR_DIM_SIZE_0 + 3'd2, s2[15:0]);
      write_csr(CSR_DIM_SIZE_0 + 3'd3, s3[15:0]);
      write_csr(CSR_DIM_SIZE_0 + 3'd4, s4[15:0]);
      write_csr(CSR_DIM_SIZE_0 + 3'd5, s5[15:0]);
      csr_valid <= 1'b0;
   endtask

   int burst_left = 0;

   task automatic send_element(logic [31:0] x);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= x;
      do @(posedge clock); while (!req_tready);
      predict_element(x);
      elements_sent++;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_tensor(int count);
      repeat (count) send_element(rand_value());
   endtask

   function automatic int tensor_elems();
      int n = 1;
      for (int d = 0; d < 6; d++) n *= size_of(d);
      return n;
   endfunction

   task automatic test_pass_through();
      configure(OP_SUM, 6'd0, 1, 1, 1, 1, 2, 3);
      send_element(32'h7FFF_FFFF);
      send_element(32'h8000_0000);
      send_element(32'hFFFF_FFFF);
      send_element(32'h0);
      send_element(32'h5555_5555);
      send_element(32'hAAAA_AAAA);
   endtask

   task automatic test_full_reduce();
      configure(OP_SUM, 6'h3F, 1, 1, 1, 1, 1, 4);
      send_element(32'h7FFF_FFFF);
      send_element(32'h0000_0001);
      send_element(32'h8000_0000);
      send_element(32'hFFFF_FFFF);
      // maximum over all negatives must not start from zero
      configure(OP_MAX, 6'h3F, 1, 1, 1, 1, 2, 2);
      send_element(32'h8000_0005);
      send_element(32'hFFFF_FFF0);
      send_element(32'h8000_0000);
      send_element(32'hFFFF_FFFE);
   endtask

   task automatic test_size_zero();
      // zero size acts as one; large outer size with a single tensor slice
      configure(OP_MAX, 6'b000001, 0, 0, 3, 0, 1, 2);
      send_tensor(tensor_elems());
      configure(OP_SUM, 6'b000011, 16'hFFFF, 1, 1, 1, 1, 1);
      send_tensor(3);
      // shrink the outer size mid-tensor so the slice finishes
      configure(OP_SUM, 6'b000011, 4, 1, 1, 1, 1, 1);
      send_tensor(1);
   endtask

   task automatic test_random_shapes();
      int s [6];
      int n;
      logic [5:0] m;
      while (elements_sent < 1100) begin
         do begin
            n = 1;
            for (int d = 0; d < 6; d++)
               s[d] = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 4);
            if ($urandom_range(0, 15) == 0) s[$urandom_range(0, 5)] = $urandom_range(5, 40);
            for (int d = 0; d < 6; d++) n *= s[d];
         end while (n > 128 || n > 1100 - elements_sent);
         m = $urandom_range(0, 63);
         configure($urandom_range(0, 1), m, s[0], s[1], s[2], s[3], s[4], s[5]);
         repeat ($urandom_range(1, 3)) begin
            if (elements_sent + n <= 1100) send_tensor(n);
         end
      end
   endtask

   initial begin
      cfg_op = OP_SUM; cfg_mask = 0; out_count = 0;
      for (int d = 0; d < 6; d++) begin
         cfg_size[d] = 1; coord[d] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pass_through();
      test_full_reduce();
      test_size_zero();
      test_random_shapes();
      drain();
      $display("sent %0d elements, checked %0d outputs over %0d tensors",
               elements_sent, outputs_seen, tensors_done);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
